/* rtl/utf8d_pkg.sv */
// Package with shared widths, constants and types of the UTF-8 decoder.
`timescale 1ns / 1ps
package utf8d_pkg;

  localparam int ByteW  = 8;
  localparam int CodeW  = 21;
  localparam int OwedW  = 2;
  localparam int TrailW = 6;

  localparam logic [ByteW-1:0] ContStart = 8'h80;
  localparam logic [ByteW-1:0] Lead2     = 8'hC0;
  localparam logic [ByteW-1:0] Lead3     = 8'hE0;
  localparam logic [ByteW-1:0] Lead4     = 8'hF0;
  localparam logic [ByteW-1:0] Mask2     = 8'h1F;
  localparam logic [ByteW-1:0] Mask3     = 8'h0F;
  localparam logic [ByteW-1:0] Mask4     = 8'h07;
  localparam logic [ByteW-1:0] MaskTrail = 8'h3F;
  localparam logic [CodeW-1:0] Replace   = 21'h00003F;  // '?'

  localparam logic [OwedW-1:0] OwedNone  = 2'd0;
  localparam logic [OwedW-1:0] OwedOne   = 2'd1;
  localparam logic [OwedW-1:0] OwedTwo   = 2'd2;
  localparam logic [OwedW-1:0] OwedThree = 2'd3;

  // Result of one decode step, handed from the core to the output stage.
  typedef struct packed {
    logic             emit;
    logic [CodeW-1:0] code_point;
    logic             final_char;
  } dec_res_t;

endpackage

/* rtl/utf8d_if.sv */
// Valid/ready channel interfaces for the byte input and the code point output.
`timescale 1ns / 1ps
interface utf8d_byte_if;
  logic                       valid;
  logic                       ready;
  logic [utf8d_pkg::ByteW-1:0] data_byte;
  logic                       string_end;

  modport source (output valid, output data_byte, output string_end, input ready);
  modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

interface utf8d_cp_if;
  logic                        valid;
  logic                        ready;
  logic [utf8d_pkg::CodeW-1:0] code_point;
  logic                        final_char;

  modport source (output valid, output code_point, output final_char, input ready);
  modport sink   (input valid, input code_point, input final_char, output ready);
endinterface

/* rtl/utf8d_core.sv */
// Decode step: sequence state registers and the per-byte shift-or update.
`timescale 1ns / 1ps
module utf8d_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [utf8d_pkg::ByteW-1:0]   data_byte,
  input  logic                          string_end,
  output utf8d_pkg::dec_res_t           res
);
  import utf8d_pkg::*;

  logic [CodeW-1:0] partial_r, partial_nxt;
  logic [OwedW-1:0] owed_r, owed_nxt;
  logic [CodeW-1:0] part_w;
  logic [OwedW-1:0] owed_w;

  always_comb begin
    part_w          = partial_r;
    owed_w          = owed_r;
    res.emit        = 1'b0;
    res.code_point  = '0;
    res.final_char  = string_end;
    partial_nxt     = partial_r;
    owed_nxt        = owed_r;
    if (owed_r == OwedNone) begin
      if (data_byte < ContStart) begin
        res.emit       = 1'b1;
        res.code_point = {{(CodeW-ByteW){1'b0}}, data_byte};
      end else if (data_byte < Lead2) begin
        res.emit       = 1'b1;
        res.code_point = Replace;
      end else begin
        priority if (data_byte < Lead3) begin
          part_w = {{(CodeW-ByteW){1'b0}}, data_byte & Mask2};
          owed_w = OwedOne;
        end else if (data_byte < Lead4) begin
          part_w = {{(CodeW-ByteW){1'b0}}, data_byte & Mask3};
          owed_w = OwedTwo;
        end else begin
          part_w = {{(CodeW-ByteW){1'b0}}, data_byte & Mask4};
          owed_w = OwedThree;
        end
        if (string_end) begin
          res.emit       = 1'b1;
          res.code_point = part_w;
        end else begin
          partial_nxt = part_w;
          owed_nxt    = owed_w;
        end
      end
    end else begin
      // Shift in the low six bits of a following byte, unchecked.
      part_w = {partial_r[CodeW-TrailW-1:0], data_byte[TrailW-1:0]};
      owed_w = owed_r - OwedOne;
      if (owed_w != OwedNone && !string_end) begin
        partial_nxt = part_w;
        owed_nxt    = owed_w;
      end else begin
        res.emit       = 1'b1;
        res.code_point = part_w;
        partial_nxt    = '0;
        owed_nxt       = OwedNone;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      owed_r    <= OwedNone;
    end else if (step) begin
      partial_r <= partial_nxt;
      owed_r    <= owed_nxt;
    end
  end

endmodule

/* rtl/utf8_to_codepoint_decoder_top.sv */
// Top level of the UTF-8 to code point decoder: input stage, core, output stage.
//
//   channel  | dir | payload                         | role
//   in_ch    | in  | data_byte[7:0], string_end      | one text byte per beat
//   out_ch   | out | code_point[20:0], final_char    | one character per beat
//
// Throughput: one byte per cycle except while a result waits on out_ch.ready; a
// byte passes the input register, the decode logic and the result register to out_ch.
// The decode path is a lead-byte mask or a shift-or, plus a two-bit counter update.
// Reset: synchronous, active low; clears the stage valid flags and the
// sequence state (partial value and owed-byte count).
// Stalls: the result register holds while out_ch.ready is low; the input
// register still takes a beat and bytes that complete no character keep
// draining into the core.
`timescale 1ns / 1ps
module utf8_to_codepoint_decoder_top (
  input logic         clk,
  input logic         rst_n,
  utf8d_byte_if.sink  in_ch,
  utf8d_cp_if.source  out_ch
);
  import utf8d_pkg::*;

  // Input register stage.
  logic             in_valid_r, in_valid_nxt;
  logic [ByteW-1:0] in_byte_r;
  logic             in_last_r;

  // Result register stage.
  logic             out_valid_r, out_valid_nxt;
  logic [CodeW-1:0] out_cp_r;
  logic             out_final_r;

  dec_res_t res;
  logic     out_free;
  logic     consume;
  logic     in_beat;

  // The output slot frees up when it is empty or its beat completes now.
  assign out_free = !out_valid_r || out_ch.ready;
  // Advance the held byte unless it makes a result with nowhere to go.
  assign consume  = in_valid_r && (!res.emit || out_free);
  assign in_ch.ready = !in_valid_r || consume;
  assign in_beat  = in_ch.valid && in_ch.ready;

  utf8d_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (consume),
    .data_byte  (in_byte_r),
    .string_end (in_last_r),
    .res        (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_beat) begin
      in_valid_nxt = 1'b1;
    end else if (consume) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (consume && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on an input beat or a result write, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.string_end;
    end
    if (consume && res.emit) begin
      out_cp_r    <= res.code_point;
      out_final_r <= res.final_char;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_point = out_cp_r;
  assign out_ch.final_char = out_final_r;

endmodule
